/* hw/rtl/s512alu_pkg.sv */
// Shared types and codes of the signed 512-bit ALU.
package s512alu_pkg;

   // Item modes
   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_RUN    = 2'd2;

   // Operation codes
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MOD = 3'd4;
   localparam logic [2:0] OP_SHL = 3'd5;
   localparam logic [2:0] OP_SHR = 3'd6;
   localparam logic [2:0] OP_CMP = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  limb_index;
      logic [31:0] limb_value;
      logic        sign_negative;
      logic [2:0]  operation;
      logic [9:0]  shift_count;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] result_limb;
      logic [3:0]  result_index;
      logic        result_negative;
      logic        is_less;
      logic        is_equal;
      logic        is_greater;
      logic        divide_by_zero;
      logic        last;
   } rsp_payload_type;

   // Datapath commands
   typedef enum logic [4:0] {
      DP_IDLE,
      DP_LOAD_A,
      DP_LOAD_B,
      DP_SCAN,
      DP_ADD,
      DP_SUB_AB,
      DP_SUB_BA,
      DP_SUB_BR,
      DP_INC_Q,
      DP_MUL_STEP,
      DP_DIV_STEP,
      DP_STEP_END_MUL,
      DP_STEP_END_DIV,
      DP_MUL_INIT,
      DP_DIV_INIT,
      DP_CLEAR,
      DP_SH_LOAD,
      DP_SHL_LIMB,
      DP_SHL_BIT,
      DP_SHR_LIMB,
      DP_SHR_BIT,
      DP_ZERO_SCAN,
      DP_EMIT,
      DP_EMIT_CMP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       first;
      logic       cin;
      logic [3:0] index;
      logic       neg;
      logic       lt;
      logic       eq;
      logic       gt;
      logic       dz;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic a_neg;
      logic b_neg;
      logic a_nz;
      logic b_nz;
      logic mag_lt;
      logic mag_eq;
      logic r_nz;
      logic take;
   } dp_status_type;

endpackage

/* hw/rtl/s512alu_if.sv */
// Valid/ready channel interfaces of the signed 512-bit ALU.
interface s512alu_req_if;
   logic                           valid;
   logic                           ready;
   s512alu_pkg::req_payload_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface s512alu_rsp_if;
   logic                           valid;
   logic                           ready;
   s512alu_pkg::rsp_payload_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/s512alu_dp.sv */
// Limb-serial datapath: operand, result and divider registers, one limb adder.
module s512alu_dp #(
   parameter int LIMB_COUNT = 16,
   parameter int LIMB_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  s512alu_pkg::dp_cmd_type       cmd,
   input  s512alu_pkg::req_payload_type  req_pl,
   output s512alu_pkg::rsp_payload_type  rsp_pl,
   output s512alu_pkg::dp_status_type    status
);
   localparam int TB = LIMB_COUNT * LIMB_BITS;
   localparam int LB = LIMB_BITS;

   logic [TB-1:0] a_ff, a_in, b_ff, b_in, r_ff, r_in, d_ff, d_in, q_ff, q_in, x_ff, x_in;
   logic          a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic          cy_ff, cy_in, bw_ff, bw_in, sh_ff, sh_in;
   logic          a_nz_ff, a_nz_in, b_nz_ff, b_nz_in, lt_ff, lt_in, eq_ff, eq_in;
   logic          r_nz_ff, r_nz_in;
   s512alu_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [LB-1:0] a0, b0, r0, q0, s_limb, lv;
   logic [LB-1:0] add_x, add_y, sub_x, sub_y;
   logic [LB:0]   add_w, sub_w;
   logic          cin_sel, bw_sel, sh_sel, take, rotate_all, eq_acc;

   assign a0 = a_ff[LB-1:0];
   assign b0 = b_ff[LB-1:0];
   assign r0 = r_ff[LB-1:0];
   assign q0 = q_ff[LB-1:0];
   assign lv = LB'(req_pl.limb_value);
   assign take = sh_ff | ~bw_ff;

   assign cin_sel = cmd.first ? cmd.cin : cy_ff;
   assign bw_sel  = cmd.first ? 1'b0 : bw_ff;
   assign sh_sel  = cmd.first ? ((cmd.op == s512alu_pkg::DP_DIV_STEP) ? x_ff[TB-1] : 1'b0)
                              : sh_ff;
   assign s_limb  = {r0[LB-2:0], sh_sel};

   always_comb begin
      add_x = a0;
      add_y = b0;
      case (cmd.op)
         s512alu_pkg::DP_INC_Q: begin
            add_x = q0;
            add_y = '0;
         end
         s512alu_pkg::DP_MUL_STEP: begin
            add_x = s_limb;
            add_y = x_ff[TB-1] ? a0 : '0;
         end
         default: begin
            add_x = a0;
            add_y = b0;
         end
      endcase
      sub_x = a0;
      sub_y = b0;
      case (cmd.op)
         s512alu_pkg::DP_SUB_BA: begin
            sub_x = b0;
            sub_y = a0;
         end
         s512alu_pkg::DP_SUB_BR: begin
            sub_x = b0;
            sub_y = r0;
         end
         s512alu_pkg::DP_DIV_STEP: begin
            sub_x = s_limb;
            sub_y = b0;
         end
         default: begin
            sub_x = a0;
            sub_y = b0;
         end
      endcase
   end

   assign add_w = {1'b0, add_x} + {1'b0, add_y} + {{LB{1'b0}}, cin_sel};
   assign sub_w = {1'b0, sub_x} - {1'b0, sub_y} - {{LB{1'b0}}, bw_sel};

   always_comb begin
      rotate_all = 1'b0;
      case (cmd.op)
         s512alu_pkg::DP_SCAN, s512alu_pkg::DP_ADD, s512alu_pkg::DP_SUB_AB,
         s512alu_pkg::DP_SUB_BA, s512alu_pkg::DP_SUB_BR, s512alu_pkg::DP_INC_Q,
         s512alu_pkg::DP_MUL_STEP, s512alu_pkg::DP_DIV_STEP,
         s512alu_pkg::DP_ZERO_SCAN: rotate_all = 1'b1;
         default: rotate_all = 1'b0;
      endcase
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      r_in = r_ff;
      d_in = d_ff;
      q_in = q_ff;
      x_in = x_ff;
      a_neg_in = a_neg_ff;
      b_neg_in = b_neg_ff;
      cy_in = cy_ff;
      bw_in = bw_ff;
      sh_in = sh_ff;
      a_nz_in = a_nz_ff;
      b_nz_in = b_nz_ff;
      lt_in = lt_ff;
      eq_in = eq_ff;
      r_nz_in = r_nz_ff;
      rsp_in = rsp_ff;
      eq_acc = cmd.first ? 1'b1 : eq_ff;

      if (rotate_all) begin
         a_in = {a0, a_ff[TB-1:LB]};
         b_in = {b0, b_ff[TB-1:LB]};
         r_in = {r0, r_ff[TB-1:LB]};
         d_in = {d_ff[LB-1:0], d_ff[TB-1:LB]};
         q_in = {q0, q_ff[TB-1:LB]};
      end

      case (cmd.op)
         s512alu_pkg::DP_LOAD_A: begin
            for (int i = 0; i < LIMB_COUNT; i++) begin
               if (int'(req_pl.limb_index) == i) a_in[i*LB +: LB] = lv;
            end
            a_neg_in = req_pl.sign_negative;
         end
         s512alu_pkg::DP_LOAD_B: begin
            for (int i = 0; i < LIMB_COUNT; i++) begin
               if (int'(req_pl.limb_index) == i) b_in[i*LB +: LB] = lv;
            end
            b_neg_in = req_pl.sign_negative;
         end
         s512alu_pkg::DP_SCAN: begin
            // low limbs first, so the highest differing limb decides
            a_nz_in = (cmd.first ? 1'b0 : a_nz_ff) | (a0 != '0);
            b_nz_in = (cmd.first ? 1'b0 : b_nz_ff) | (b0 != '0);
            if (a0 != b0) begin
               lt_in = a0 < b0;
               eq_in = 1'b0;
            end else begin
               lt_in = cmd.first ? 1'b0 : lt_ff;
               eq_in = eq_acc;
            end
         end
         s512alu_pkg::DP_ADD, s512alu_pkg::DP_INC_Q, s512alu_pkg::DP_MUL_STEP: begin
            r_in  = {add_w[LB-1:0], r_ff[TB-1:LB]};
            cy_in = add_w[LB];
            sh_in = r0[LB-1];
         end
         s512alu_pkg::DP_SUB_AB, s512alu_pkg::DP_SUB_BA, s512alu_pkg::DP_SUB_BR: begin
            r_in  = {sub_w[LB-1:0], r_ff[TB-1:LB]};
            bw_in = sub_w[LB];
         end
         s512alu_pkg::DP_DIV_STEP: begin
            r_in  = {s_limb, r_ff[TB-1:LB]};
            d_in  = {sub_w[LB-1:0], d_ff[TB-1:LB]};
            bw_in = sub_w[LB];
            sh_in = r0[LB-1];
         end
         s512alu_pkg::DP_STEP_END_MUL: x_in = {x_ff[TB-2:0], 1'b0};
         s512alu_pkg::DP_STEP_END_DIV: begin
            if (take) r_in = d_ff;
            q_in = {q_ff[TB-2:0], take};
            x_in = {x_ff[TB-2:0], 1'b0};
         end
         s512alu_pkg::DP_MUL_INIT: begin
            r_in = '0;
            x_in = b_ff;
         end
         s512alu_pkg::DP_DIV_INIT: begin
            r_in = '0;
            q_in = '0;
            x_in = a_ff;
         end
         s512alu_pkg::DP_CLEAR:    r_in = '0;
         s512alu_pkg::DP_SH_LOAD:  r_in = a_ff;
         s512alu_pkg::DP_SHL_LIMB: r_in = r_ff << LB;
         s512alu_pkg::DP_SHL_BIT:  r_in = r_ff << 1;
         s512alu_pkg::DP_SHR_LIMB: r_in = r_ff >> LB;
         s512alu_pkg::DP_SHR_BIT:  r_in = r_ff >> 1;
         s512alu_pkg::DP_ZERO_SCAN:
            r_nz_in = (cmd.first ? 1'b0 : r_nz_ff) | (r0 != '0);
         s512alu_pkg::DP_EMIT: begin
            r_in = {r0, r_ff[TB-1:LB]};
            rsp_in.result_limb     = 32'(r0);
            rsp_in.result_index    = cmd.index;
            rsp_in.result_negative = cmd.neg;
            rsp_in.is_less         = 1'b0;
            rsp_in.is_equal        = 1'b0;
            rsp_in.is_greater      = 1'b0;
            rsp_in.divide_by_zero  = cmd.dz;
            rsp_in.last            = cmd.last;
         end
         s512alu_pkg::DP_EMIT_CMP: begin
            rsp_in.result_limb     = '0;
            rsp_in.result_index    = '0;
            rsp_in.result_negative = 1'b0;
            rsp_in.is_less         = cmd.lt;
            rsp_in.is_equal        = cmd.eq;
            rsp_in.is_greater      = cmd.gt;
            rsp_in.divide_by_zero  = 1'b0;
            rsp_in.last            = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_neg_ff <= 1'b0;
         b_neg_ff <= 1'b0;
      end else begin
         a_neg_ff <= a_neg_in;
         b_neg_ff <= b_neg_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      x_ff    <= x_in;
      cy_ff   <= cy_in;
      bw_ff   <= bw_in;
      sh_ff   <= sh_in;
      a_nz_ff <= a_nz_in;
      b_nz_ff <= b_nz_in;
      lt_ff   <= lt_in;
      eq_ff   <= eq_in;
      r_nz_ff <= r_nz_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_pl = rsp_ff;

   always_comb begin
      status.a_neg  = a_neg_ff;
      status.b_neg  = b_neg_ff;
      status.a_nz   = a_nz_ff;
      status.b_nz   = b_nz_ff;
      status.mag_lt = lt_ff;
      status.mag_eq = eq_ff;
      status.r_nz   = r_nz_ff;
      status.take   = take;
   end
endmodule

/* hw/rtl/s512alu_ctrl.sv */
// Sequencer of the signed 512-bit ALU: passes, bit steps and result streaming.
module s512alu_ctrl #(
   parameter int LIMB_COUNT = 16,
   parameter int LIMB_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  s512alu_pkg::req_payload_type  req_pl,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  s512alu_pkg::dp_status_type    status,
   output s512alu_pkg::dp_cmd_type       cmd
);
   localparam int TOTAL = LIMB_COUNT * LIMB_BITS;
   localparam int LCW   = $clog2(LIMB_COUNT);
   localparam int SW    = $clog2(TOTAL);
   localparam int TW    = $clog2(TOTAL + 1);
   localparam int CW    = (TW > 10) ? TW : 10;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_SCAN      = 12'b0000_0000_0010,
      ST_DISPATCH  = 12'b0000_0000_0100,
      ST_ADDSUB    = 12'b0000_0000_1000,
      ST_STEP_PASS = 12'b0000_0001_0000,
      ST_STEP_END  = 12'b0000_0010_0000,
      ST_ZREM      = 12'b0000_0100_0000,
      ST_FIX       = 12'b0000_1000_0000,
      ST_SHIFT     = 12'b0001_0000_0000,
      ST_ZRES      = 12'b0010_0000_0000,
      ST_EMIT      = 12'b0100_0000_0000,
      ST_CMP       = 12'b1000_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [LCW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]  step_ff, step_in;
   logic [CW-1:0]  shamt_ff, shamt_in;
   logic [2:0]     op_ff, op_in;
   logic           neg_ff, neg_in, dz_ff, dz_in, rsp_valid_ff, rsp_valid_in;
   logic           pass_last, slot_free, an, bn, be, accept;

   assign pass_last = cnt_ff == LCW'(LIMB_COUNT - 1);
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign an        = status.a_neg & status.a_nz;
   assign bn        = status.b_neg & status.b_nz;
   assign be        = (op_ff == s512alu_pkg::OP_SUB) ? ~bn : bn;
   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      shamt_in     = shamt_ff;
      op_in        = op_ff;
      neg_in       = neg_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = s512alu_pkg::DP_IDLE;
      cmd.first    = cnt_ff == '0;
      cmd.cin      = 1'b0;
      cmd.index    = 4'(cnt_ff);
      cmd.neg      = neg_ff & status.r_nz;
      cmd.lt       = 1'b0;
      cmd.eq       = 1'b0;
      cmd.gt       = 1'b0;
      cmd.dz       = dz_ff;
      cmd.last     = pass_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_pl.mode)
                  s512alu_pkg::MODE_LOAD_A: cmd.op = s512alu_pkg::DP_LOAD_A;
                  s512alu_pkg::MODE_LOAD_B: cmd.op = s512alu_pkg::DP_LOAD_B;
                  s512alu_pkg::MODE_RUN: begin
                     op_in    = req_pl.operation;
                     shamt_in = CW'(req_pl.shift_count);
                     dz_in    = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.op = s512alu_pkg::DP_SCAN;
            cnt_in = pass_last ? '0 : cnt_ff + 1'b1;
            if (pass_last) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            step_in = '0;
            case (op_ff)
               s512alu_pkg::OP_ADD, s512alu_pkg::OP_SUB: state_in = ST_ADDSUB;
               s512alu_pkg::OP_MUL: begin
                  cmd.op   = s512alu_pkg::DP_MUL_INIT;
                  neg_in   = an ^ bn;
                  state_in = ST_STEP_PASS;
               end
               s512alu_pkg::OP_DIV, s512alu_pkg::OP_MOD: begin
                  if (!status.b_nz) begin
                     cmd.op   = s512alu_pkg::DP_CLEAR;
                     dz_in    = 1'b1;
                     neg_in   = 1'b0;
                     state_in = ST_ZRES;
                  end else begin
                     cmd.op   = s512alu_pkg::DP_DIV_INIT;
                     state_in = ST_STEP_PASS;
                  end
               end
               s512alu_pkg::OP_SHL, s512alu_pkg::OP_SHR: begin
                  cmd.op   = s512alu_pkg::DP_SH_LOAD;
                  neg_in   = an;
                  state_in = ST_SHIFT;
               end
               default: state_in = ST_CMP;
            endcase
         end
         ST_ADDSUB: begin
            // like signs add, unlike signs take the larger magnitude minus the smaller
            if (an == be) begin
               cmd.op = s512alu_pkg::DP_ADD;
               neg_in = an;
            end else if (!status.mag_lt) begin
               cmd.op = s512alu_pkg::DP_SUB_AB;
               neg_in = an;
            end else begin
               cmd.op = s512alu_pkg::DP_SUB_BA;
               neg_in = be;
            end
            cnt_in = pass_last ? '0 : cnt_ff + 1'b1;
            if (pass_last) state_in = ST_ZRES;
         end
         ST_STEP_PASS: begin
            cmd.op = (op_ff == s512alu_pkg::OP_MUL) ? s512alu_pkg::DP_MUL_STEP
                                                    : s512alu_pkg::DP_DIV_STEP;
            cnt_in = pass_last ? '0 : cnt_ff + 1'b1;
            if (pass_last) state_in = ST_STEP_END;
         end
         ST_STEP_END: begin
            cmd.op = (op_ff == s512alu_pkg::OP_MUL) ? s512alu_pkg::DP_STEP_END_MUL
                                                    : s512alu_pkg::DP_STEP_END_DIV;
            if (step_ff == SW'(TOTAL - 1)) begin
               state_in = (op_ff == s512alu_pkg::OP_MUL) ? ST_ZRES : ST_ZREM;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_STEP_PASS;
            end
         end
         ST_ZREM: begin
            cmd.op = s512alu_pkg::DP_ZERO_SCAN;
            cnt_in = pass_last ? '0 : cnt_ff + 1'b1;
            if (pass_last) state_in = ST_FIX;
         end
         ST_FIX: begin
            if (op_ff == s512alu_pkg::OP_DIV) begin
               // negative dividend with a remainder rounds the quotient away
               cmd.op  = s512alu_pkg::DP_INC_Q;
               cmd.cin = an & status.r_nz;
               neg_in  = an ^ bn;
               cnt_in  = pass_last ? '0 : cnt_ff + 1'b1;
               if (pass_last) state_in = ST_ZRES;
            end else begin
               neg_in = 1'b0;
               if (an & status.r_nz) begin
                  cmd.op = s512alu_pkg::DP_SUB_BR;
                  cnt_in = pass_last ? '0 : cnt_ff + 1'b1;
                  if (pass_last) state_in = ST_ZRES;
               end else begin
                  state_in = ST_ZRES;
               end
            end
         end
         ST_SHIFT: begin
            if (shamt_ff >= CW'(TOTAL)) begin
               cmd.op   = s512alu_pkg::DP_CLEAR;
               state_in = ST_ZRES;
            end else if (shamt_ff >= CW'(LIMB_BITS)) begin
               cmd.op   = (op_ff == s512alu_pkg::OP_SHL) ? s512alu_pkg::DP_SHL_LIMB
                                                         : s512alu_pkg::DP_SHR_LIMB;
               shamt_in = shamt_ff - CW'(LIMB_BITS);
            end else if (shamt_ff != '0) begin
               cmd.op   = (op_ff == s512alu_pkg::OP_SHL) ? s512alu_pkg::DP_SHL_BIT
                                                         : s512alu_pkg::DP_SHR_BIT;
               shamt_in = shamt_ff - 1'b1;
            end else begin
               state_in = ST_ZRES;
            end
         end
         ST_ZRES: begin
            cmd.op = s512alu_pkg::DP_ZERO_SCAN;
            cnt_in = pass_last ? '0 : cnt_ff + 1'b1;
            if (pass_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.op       = s512alu_pkg::DP_EMIT;
               rsp_valid_in = 1'b1;
               cnt_in       = pass_last ? '0 : cnt_ff + 1'b1;
               if (pass_last) state_in = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (an != bn) begin
               cmd.lt = an;
               cmd.gt = bn;
            end else if (status.mag_eq) begin
               cmd.eq = 1'b1;
            end else begin
               cmd.lt = status.mag_lt ^ an;
               cmd.gt = ~status.mag_lt ^ an;
            end
            if (slot_free) begin
               cmd.op       = s512alu_pkg::DP_EMIT_CMP;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      shamt_ff <= shamt_in;
      op_ff    <= op_in;
      neg_ff   <= neg_in;
      dz_ff    <= dz_in;
   end
endmodule

/* hw/rtl/signed_512bit_integer_alu_unit.sv */
// Top level of the signed 512-bit sign-magnitude integer ALU.
//
// Load words write one limb of the first or second operand and take that
// operand's sign; a run word then computes add, subtract, low half of
// multiply, Euclidean divide, non-negative Euclidean modulo, magnitude shift
// left or right, or compare, and streams LIMB_COUNT result words, least
// significant limb first (compare gives one word). Every run first walks the
// operands once for zero and magnitude order, and every limb result is walked
// once more for its zero check before streaming. One limb adder and one limb
// subtractor do all arithmetic, one limb per cycle. Multiply and divide run
// LIMB_COUNT*LIMB_BITS bit steps, each a pass over all limbs and an end step;
// shifts move by whole limbs, then by single bits, and clear the result for
// counts of the full width or more. The input is held off for the whole run.
// Results sit in an output register, so a stalled result port does not hold
// up a load after the last word.
module signed_512bit_integer_alu_unit #(
   parameter int LIMB_COUNT = 16,
   parameter int LIMB_BITS  = 32
) (
   input  logic          clock,
   input  logic          reset,
   s512alu_req_if.sink   req_ch,
   s512alu_rsp_if.source rsp_ch
);
   s512alu_pkg::dp_cmd_type    cmd;
   s512alu_pkg::dp_status_type status;

   // sequencer: owns handshakes and pass/step counting
   s512alu_ctrl #(
      .LIMB_COUNT (LIMB_COUNT),
      .LIMB_BITS  (LIMB_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_pl    (req_ch.payload),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: operand registers, limb adder, result word register
   s512alu_dp #(
      .LIMB_COUNT (LIMB_COUNT),
      .LIMB_BITS  (LIMB_BITS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .req_pl (req_ch.payload),
      .rsp_pl (rsp_ch.payload),
      .status (status)
   );
endmodule

/* sim/signed_512bit_integer_alu_unit_checker.sv */
// Checker for the signed 512-bit ALU: predicts result words and compares them.
`timescale 1ns / 100ps

module signed_512bit_integer_alu_unit_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  s512alu_pkg::req_payload_type req_payload,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  s512alu_pkg::rsp_payload_type rsp_payload,
   output int                           fail_count,
   output int                           pending_count,
   output int                           rsp_count
);

   localparam int NBITS = 512;

   logic [NBITS-1:0]             first_mag, second_mag;
   logic                         first_neg, second_neg;
   s512alu_pkg::rsp_payload_type expected_words[$];

   assign pending_count = expected_words.size();

   task automatic predict_run(input logic [2:0] op, input logic [9:0] count);
      logic [NBITS-1:0]             res, quo, rem;
      logic                         an, bn, be, neg, dz;
      s512alu_pkg::rsp_payload_type w;
      an = first_neg && (first_mag != 0);
      bn = second_neg && (second_mag != 0);
      neg = 1'b0;
      dz = 1'b0;
      res = '0;
      w = '0;
      if (op == s512alu_pkg::OP_CMP) begin
         if (an != bn) begin
            w.is_less = an;
            w.is_greater = !an;
         end else if (first_mag == second_mag) begin
            w.is_equal = 1'b1;
         end else begin
            w.is_less = (first_mag < second_mag) ^ an;
            w.is_greater = !w.is_less;
         end
         w.last = 1'b1;
         expected_words.push_back(w);
         return;
      end
      case (op)
         s512alu_pkg::OP_ADD, s512alu_pkg::OP_SUB: begin
            be = (op == s512alu_pkg::OP_SUB) ? !bn : bn;
            if (an == be) begin
               res = first_mag + second_mag;
               neg = an;
            end else if (first_mag >= second_mag) begin
               res = first_mag - second_mag;
               neg = an;
            end else begin
               res = second_mag - first_mag;
               neg = be;
            end
         end
         s512alu_pkg::OP_MUL: begin
            res = first_mag * second_mag;
            neg = an != bn;
         end
         s512alu_pkg::OP_DIV, s512alu_pkg::OP_MOD: begin
            if (second_mag == 0) begin
               dz = 1'b1;
            end else begin
               quo = first_mag / second_mag;
               rem = first_mag % second_mag;
               if (op == s512alu_pkg::OP_DIV) begin
                  res = (an && rem != 0) ? quo + 1 : quo;
                  neg = an != bn;
               end else begin
                  res = (an && rem != 0) ? second_mag - rem : rem;
               end
            end
         end
         s512alu_pkg::OP_SHL: begin
            res = (count >= NBITS) ? '0 : first_mag << count;
            neg = an;
         end
         default: begin
            res = (count >= NBITS) ? '0 : first_mag >> count;
            neg = an;
         end
      endcase
      if (res == 0) neg = 1'b0;
      for (int k = 0; k < 16; k++) begin
         w = '0;
         w.result_limb = res[k*32 +: 32];
         w.result_index = k[3:0];
         w.result_negative = neg;
         w.divide_by_zero = dz;
         w.last = (k == 15);
         expected_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_neg <= 1'b0;
         second_neg <= 1'b0;
         first_mag <= '0;
         second_mag <= '0;
      end else if (req_valid && req_ready) begin
         case (req_payload.mode)
            s512alu_pkg::MODE_LOAD_A: begin
               first_mag[req_payload.limb_index*32 +: 32] <= req_payload.limb_value;
               first_neg <= req_payload.sign_negative;
            end
            s512alu_pkg::MODE_LOAD_B: begin
               second_mag[req_payload.limb_index*32 +: 32] <= req_payload.limb_value;
               second_neg <= req_payload.sign_negative;
            end
            s512alu_pkg::MODE_RUN:
               predict_run(req_payload.operation, req_payload.shift_count);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      s512alu_pkg::rsp_payload_type e;
      if (reset) begin
         fail_count <= 0;
         rsp_count <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_words.size() == 0) begin
            $error("unexpected result word %p", rsp_payload);
            fail_count <= fail_count + 1;
         end else begin
            e = expected_words.pop_front();
            if (e !== rsp_payload) begin
               if (e.result_limb !== rsp_payload.result_limb)
                  $error("result_limb exp %h got %h", e.result_limb, rsp_payload.result_limb);
               if (e.result_index !== rsp_payload.result_index)
                  $error("result_index exp %0d got %0d", e.result_index,
                         rsp_payload.result_index);
               if (e.result_negative !== rsp_payload.result_negative)
                  $error("result_negative exp %b got %b", e.result_negative,
                         rsp_payload.result_negative);
               if (e.is_less !== rsp_payload.is_less)
                  $error("is_less exp %b got %b", e.is_less, rsp_payload.is_less);
               if (e.is_equal !== rsp_payload.is_equal)
                  $error("is_equal exp %b got %b", e.is_equal, rsp_payload.is_equal);
               if (e.is_greater !== rsp_payload.is_greater)
                  $error("is_greater exp %b got %b", e.is_greater, rsp_payload.is_greater);
               if (e.divide_by_zero !== rsp_payload.divide_by_zero)
                  $error("divide_by_zero exp %b got %b", e.divide_by_zero,
                         rsp_payload.divide_by_zero);
               if (e.last !== rsp_payload.last)
                  $error("last exp %b got %b", e.last, rsp_payload.last);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

/* sim/signed_512bit_integer_alu_unit_tb.sv */
// Testbench top for the signed 512-bit ALU: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module signed_512bit_integer_alu_unit_tb;

   // Limit on cycles with no word moving; set above the slowest run, a multiply or divide.
   localparam int WATCHDOG_LIMIT = 60000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, rsp_count;
   int   idle_cycles = 0;
   int   run_count = 0;
   int   item_count = 0;
   bit   stall_mode = 1'b0;

   s512alu_req_if req_ch ();
   s512alu_rsp_if rsp_ch ();

   always #5 clock = ~clock;

   signed_512bit_integer_alu_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   signed_512bit_integer_alu_unit_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_payload   (req_ch.payload),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_ch.payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count)
   );

   // Watchdog: count cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", pending_count);
         $display("signed_512bit_integer_alu_unit test failed");
         $finish;
      end
   end

   // Receiver: alternate between free-running stretches and a random stall pattern.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
         rsp_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // Drive one word and hold it until accepted; insert a gap only between bursts.
   int burst_left = 0;
   task automatic send_word(input s512alu_pkg::req_payload_type p);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      item_count++;
      req_ch.valid <= 1'b1;
      req_ch.payload <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_limb(input logic [1:0] m, input logic [3:0] idx,
                            input logic [31:0] v, input logic s);
      s512alu_pkg::req_payload_type p;
      p = '0;
      p.mode = m;
      p.limb_index = idx;
      p.limb_value = v;
      p.sign_negative = s;
      p.operation = 3'($urandom);
      p.shift_count = 10'($urandom);
      send_word(p);
   endtask

   task automatic run_op(input logic [2:0] op, input logic [9:0] count);
      s512alu_pkg::req_payload_type p;
      p = '0;
      p.mode = s512alu_pkg::MODE_RUN;
      p.limb_index = 4'($urandom);
      p.limb_value = $urandom;
      p.sign_negative = 1'($urandom);
      p.operation = op;
      p.shift_count = count;
      send_word(p);
      run_count++;
   endtask

   // Pick a limb value that favors zero, all ones, top bit and small numbers.
   function automatic logic [31:0] pick_limb();
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'($urandom_range(1, 9));
         default: return $urandom;
      endcase
   endfunction

   // Load a whole operand of random width (upper limbs zero) with one sign.
   task automatic load_operand(input logic [1:0] m, input int top);
      logic s;
      s = 1'($urandom);
      for (int k = 0; k < 16; k++)
         load_limb(m, k[3:0], (k <= top) ? pick_limb() : 32'h0, s);
   endtask

   initial begin
      logic [9:0] count;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: a full-width first operand of all ones and a zero second operand, then every operation.
      for (int k = 0; k < 16; k++)
         load_limb(s512alu_pkg::MODE_LOAD_A, k[3:0], 32'hFFFF_FFFF, 1'b1);
      for (int k = 0; k < 16; k++)
         load_limb(s512alu_pkg::MODE_LOAD_B, k[3:0], 32'h0, 1'b1);
      // Negative zero divisor: divide by zero; a negative first operand compares less than a negative zero
      run_op(s512alu_pkg::OP_DIV, 10'd0);
      run_op(s512alu_pkg::OP_MOD, 10'd0);
      load_limb(s512alu_pkg::MODE_LOAD_A, 4'd0, 32'h0, 1'b1);
      run_op(s512alu_pkg::OP_CMP, 10'd0);
      load_limb(s512alu_pkg::MODE_LOAD_B, 4'd0, 32'd3, 1'b1);
      load_limb(s512alu_pkg::MODE_LOAD_A, 4'd0, 32'd7, 1'b1);
      // Both negative with a remainder: quotient rounds away, modulo stays positive
      run_op(s512alu_pkg::OP_DIV, 10'd0);
      run_op(s512alu_pkg::OP_MOD, 10'd0);
      run_op(s512alu_pkg::OP_ADD, 10'd0);
      run_op(s512alu_pkg::OP_SUB, 10'd0);
      run_op(s512alu_pkg::OP_MUL, 10'd0);
      run_op(s512alu_pkg::OP_SHL, 10'd512);
      run_op(s512alu_pkg::OP_SHR, 10'd511);
      run_op(s512alu_pkg::OP_SHL, 10'd1023);
      // Mode three is ignored by the block
      begin
         s512alu_pkg::req_payload_type p;
         p = '0;
         p.mode = 2'd3;
         send_word(p);
      end

      // Random: mostly full operand loads followed by a few runs.
      while (item_count < 365) begin
         if ($urandom_range(0, 3) == 0) begin
            load_limb(s512alu_pkg::MODE_LOAD_A, 4'($urandom), pick_limb(), 1'($urandom));
            load_limb(s512alu_pkg::MODE_LOAD_B, 4'($urandom), pick_limb(), 1'($urandom));
         end else begin
            load_operand(s512alu_pkg::MODE_LOAD_A, $urandom_range(0, 15));
            load_operand(s512alu_pkg::MODE_LOAD_B, $urandom_range(0, 3) == 0 ? -1 :
                                                   $urandom_range(0, 15));
         end
         repeat ($urandom_range(1, 3)) begin
            count = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                    10'($urandom_range(0, 80));
            run_op(3'($urandom), count);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("sent %0d words with %0d runs over all eight operations",
               item_count, run_count);
      $display("checked %0d result words under random input gaps and output stalls",
               rsp_count);
      if (fail_count == 0)
         $display("signed_512bit_integer_alu_unit test passed");
      else
         $display("signed_512bit_integer_alu_unit test failed");
      $finish;
   end

endmodule

/* signed_512bit_integer_alu_unit.f */
hw/rtl/s512alu_pkg.sv
hw/rtl/s512alu_if.sv
hw/rtl/s512alu_dp.sv
hw/rtl/s512alu_ctrl.sv
hw/rtl/signed_512bit_integer_alu_unit.sv
sim/signed_512bit_integer_alu_unit_checker.sv
sim/signed_512bit_integer_alu_unit_tb.sv
